[rtl/core/cdl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_pkg: shared types and constants of the Chebyshev derivative line
// Widths of the line store, the recurrence sums and the scaled results, the
// configuration register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package cdl_pkg;

  localparam int MAX_LINE  = 64;
  localparam int ADDR_W    = $clog2(MAX_LINE);
  localparam int LEN_W     = $clog2(MAX_LINE) + 1;
  localparam int COEF_W    = 32;
  localparam int SCALE_W   = 32;
  localparam int SUM_W     = 46;
  localparam int DERIV_W   = 48;
  localparam int SHORT_MIN = 5;   // lines shorter than this give all-zero results

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_SCALE = 1'b1;

  localparam logic [LEN_W-1:0]   LINE_LENGTH_RST    = LEN_W'(MAX_LINE);
  localparam logic [SCALE_W-1:0] INTERVAL_SCALE_RST = SCALE_W'(65536);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECUR,
    ST_EMIT
  } seq_state_t;

  // one step of the backward recurrence
  typedef struct packed {
    logic              clear;
    logic              valid;
    logic [ADDR_W-1:0] k;
  } recur_step_t;

  // tag travelling alongside a result read from the derivative store
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] idx;
    logic              last;
    logic              zero;
  } emit_tag_t;

endpackage

[rtl/core/cdl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/cdl_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_seq: line sequencer
// Counts loads, runs the backward recurrence addresses and the emission reads.
// ----------------------------------------------------------------------------
module cdl_seq (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [cdl_pkg::LEN_W-1:0]        line_length,
  output logic                             coef_we,
  output logic [cdl_pkg::ADDR_W-1:0]       coef_waddr,
  output logic [cdl_pkg::ADDR_W-1:0]       coef_raddr,
  output logic                             deriv_we,
  output logic [cdl_pkg::ADDR_W-1:0]       deriv_waddr,
  output logic [cdl_pkg::ADDR_W-1:0]       deriv_raddr,
  output cdl_pkg::recur_step_t             step,
  output cdl_pkg::emit_tag_t               tag
);
  import cdl_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [LEN_W-1:0]  load_count_r, load_count_nxt;
  logic [LEN_W-1:0]  n_r, n_nxt;
  logic [ADDR_W-1:0] rd_k_r, rd_k_nxt;
  logic              issuing_r, issuing_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [ADDR_W-1:0] s1_k_r, s1_k_nxt;
  logic [ADDR_W-1:0] em_idx_r, em_idx_nxt;

  logic [LEN_W-1:0]  eff_n;
  logic              line_done;
  logic              accept;
  logic              complete;
  logic [ADDR_W-1:0] n_last;
  logic              em_last;

  // clamp the configured length into 1..MAX_LINE
  always_comb begin
    if (line_length == '0) begin
      eff_n = LEN_W'(1);
    end else if (line_length > LEN_W'(MAX_LINE)) begin
      eff_n = LEN_W'(MAX_LINE);
    end else begin
      eff_n = line_length;
    end
  end

  assign line_done = (load_count_r + LEN_W'(1)) >= eff_n;
  // the completing load waits until the previous line has left the store
  assign busy      = (state_r == ST_RECUR) || ((state_r == ST_EMIT) && line_done);
  assign accept    = start && !busy;
  assign complete  = accept && line_done;
  assign n_last    = ADDR_W'(n_r - LEN_W'(1));
  assign em_last   = (em_idx_r == n_last);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (complete) begin
          state_nxt = (eff_n >= LEN_W'(SHORT_MIN)) ? ST_RECUR : ST_EMIT;
        end
      end
      ST_RECUR: begin
        if (s1_valid_r && (s1_k_r == '0)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (em_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    load_count_nxt = load_count_r;
    n_nxt          = n_r;
    rd_k_nxt       = rd_k_r;
    issuing_nxt    = issuing_r;
    s1_valid_nxt   = (state_r == ST_RECUR) && issuing_r;
    s1_k_nxt       = rd_k_r;
    em_idx_nxt     = em_idx_r;
    if (accept) begin
      load_count_nxt = line_done ? '0 : load_count_r + LEN_W'(1);
    end
    if (complete) begin
      n_nxt       = eff_n;
      rd_k_nxt    = ADDR_W'(eff_n - LEN_W'(2));
      issuing_nxt = 1'b1;
      em_idx_nxt  = '0;
    end else if (state_r == ST_RECUR && issuing_r) begin
      rd_k_nxt = rd_k_r - ADDR_W'(1);
      if (rd_k_r == '0) begin
        issuing_nxt = 1'b0;
      end
    end else if (state_r == ST_EMIT) begin
      em_idx_nxt = em_idx_r + ADDR_W'(1);
    end
  end

  // outputs
  always_comb begin
    coef_we     = accept;
    coef_waddr  = load_count_r[ADDR_W-1:0];
    coef_raddr  = rd_k_r + ADDR_W'(1);
    deriv_we    = (state_r == ST_RECUR) && (s1_valid_r || issuing_r);
    deriv_waddr = s1_valid_r ? s1_k_r : n_last;
    deriv_raddr = em_idx_r;
    step.clear  = complete;
    step.valid  = (state_r == ST_RECUR) && s1_valid_r;
    step.k      = s1_k_r;
    tag.valid   = (state_r == ST_EMIT);
    tag.idx     = em_idx_r;
    tag.last    = em_last;
    tag.zero    = (n_r < LEN_W'(SHORT_MIN));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      load_count_r <= '0;
      issuing_r    <= 1'b0;
      s1_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      load_count_r <= load_count_nxt;
      issuing_r    <= issuing_nxt;
      s1_valid_r   <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    rd_k_r   <= rd_k_nxt;
    s1_k_r   <= s1_k_nxt;
    em_idx_r <= em_idx_nxt;
  end

  a_recur_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RECUR) |-> busy)
    else $error("load taken during recurrence");

  a_deriv_addr: assert property (@(posedge clk) disable iff (!rst_n)
    deriv_we |-> ({1'b0, deriv_waddr} < n_r))
    else $error("derivative write beyond line length");

  a_emit_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && em_last) |=> (state_r == ST_IDLE))
    else $error("emission did not end after last index");

endmodule

[rtl/core/cdl_recur.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_recur: backward recurrence datapath
// Keeps the even and odd running sums and forms d[k] for the store.
// ----------------------------------------------------------------------------
module cdl_recur (
  input  logic                         clk,
  input  cdl_pkg::recur_step_t         step,
  input  logic [cdl_pkg::COEF_W-1:0]   coef,
  output logic [cdl_pkg::DERIV_W-1:0]  wdata
);
  import cdl_pkg::*;

  localparam int TERM_W = COEF_W + LEN_W + 1;

  logic signed [SUM_W-1:0]  sum_r [2];
  logic signed [SUM_W-1:0]  sum_nxt;
  logic        [LEN_W-1:0]  kp1;
  logic signed [TERM_W-1:0] prod;
  logic signed [SUM_W-1:0]  term;
  logic signed [SUM_W-1:0]  dval;

  assign kp1  = {1'b0, step.k} + LEN_W'(1);
  // c[k+1] * (k+1); doubled by the shift below
  assign prod = $signed(coef) * $signed({1'b0, kp1});
  assign term = SUM_W'(prod) <<< 1;
  assign sum_nxt = sum_r[step.k[0]] + term;
  // halve d[0] with floor
  assign dval = (step.k == '0) ? (sum_nxt >>> 1) : sum_nxt;
  // the first write of a line is d[N-1] = 0
  assign wdata = step.valid ? DERIV_W'(dval) : '0;

  always_ff @(posedge clk) begin
    if (step.clear) begin
      sum_r[0] <= '0;
      sum_r[1] <= '0;
    end else if (step.valid) begin
      sum_r[step.k[0]] <= sum_nxt;
    end
  end

endmodule

[rtl/core/cdl_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdl_scale: result scaling pipeline
// Multiplies d[k] by the interval scale in two partial products, floors to
// Q32.16 and saturates to 48 bits. One result per cycle, with registered partial products and a registered result.
// ----------------------------------------------------------------------------
module cdl_scale (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cdl_pkg::emit_tag_t            tag_in,
  input  logic [cdl_pkg::DERIV_W-1:0]   rdata,
  input  logic [cdl_pkg::SCALE_W-1:0]   scale,
  output logic                          out_valid,
  output logic [cdl_pkg::ADDR_W-1:0]    out_idx,
  output logic [cdl_pkg::DERIV_W-1:0]   out_value,
  output logic                          out_last
);
  import cdl_pkg::*;

  localparam int LO_W   = SUM_W / 2;
  localparam int HI_W   = SUM_W - LO_W;
  localparam int PLO_W  = LO_W + 1 + SCALE_W;
  localparam int PHI_W  = HI_W + SCALE_W;
  localparam int FULL_W = SUM_W + SCALE_W;
  localparam int SHR_W  = FULL_W - 16;

  emit_tag_t                tag0_r, tag1_r, tag2_r;
  logic signed [PLO_W-1:0]  plo1_r, plo2_r;
  logic signed [HI_W-1:0]   dhi1_r;
  logic signed [PHI_W-1:0]  phi2_r;
  logic signed [FULL_W-1:0] full;
  logic signed [SHR_W-1:0]  shr;
  logic                     ovf;
  logic [DERIV_W-1:0]       sat;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_idx_r;
  logic [DERIV_W-1:0] out_value_r;
  logic              out_last_r;

  assign full = (FULL_W'(phi2_r) <<< LO_W) + FULL_W'(plo2_r);
  assign shr  = full[FULL_W-1:16];
  assign ovf  = (shr[SHR_W-1:DERIV_W-1] != '0) && (shr[SHR_W-1:DERIV_W-1] != '1);

  always_comb begin
    if (ovf) begin
      sat = shr[SHR_W-1] ? {1'b1, {(DERIV_W-1){1'b0}}} : {1'b0, {(DERIV_W-1){1'b1}}};
    end else begin
      sat = shr[DERIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    tag0_r.idx  <= tag_in.idx;
    tag0_r.last <= tag_in.last;
    tag0_r.zero <= tag_in.zero;
    tag1_r.idx  <= tag0_r.idx;
    tag1_r.last <= tag0_r.last;
    tag1_r.zero <= tag0_r.zero;
    tag2_r.idx  <= tag1_r.idx;
    tag2_r.last <= tag1_r.last;
    tag2_r.zero <= tag1_r.zero;
    // low part unsigned, high part carries the sign
    plo1_r <= $signed({1'b0, rdata[LO_W-1:0]}) * $signed(scale);
    dhi1_r <= $signed(rdata[SUM_W-1:LO_W]);
    plo2_r <= plo1_r;
    phi2_r <= dhi1_r * $signed(scale);
    out_idx_r   <= tag2_r.idx;
    out_last_r  <= tag2_r.last;
    out_value_r <= tag2_r.zero ? '0 : sat;
    if (!rst_n) begin
      tag0_r.valid <= 1'b0;
      tag1_r.valid <= 1'b0;
      tag2_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tag0_r.valid <= tag_in.valid;
      tag1_r.valid <= tag0_r.valid;
      tag2_r.valid <= tag1_r.valid;
      out_valid_r  <= tag2_r.valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(tag_in.valid, 4))
    else $error("result without matching store read");

endmodule

[rtl/core/chebyshev_derivative_line.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chebyshev_derivative_line: derivative of a Chebyshev series, one line
// Loads N Q16.16 coefficients and emits the N scaled derivative coefficients.
// ----------------------------------------------------------------------------
// Load the N coefficients of a line one per transfer on in_coef_in (start
// high while busy is low), lowest index first. The transfer of the last one
// starts the backward recurrence, in which the line store is read once per
// cycle and the even and odd running sums fill the derivative store, one
// entry per cycle. The results then leave in ascending order, one per cycle
// on out_valid, with out_line_last on index N-1; the receiver cannot stall
// them. The loads of the next line may overlap the emission of the previous
// one, but its final load is held off (busy) until the derivative store has
// been read out. Lines shorter than five coefficients skip the recurrence
// and give all-zero results. Write cfg_* only while no line is in flight.
// ----------------------------------------------------------------------------
module chebyshev_derivative_line (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [cdl_pkg::COEF_W-1:0]        in_coef_in,
  output logic                              out_valid,
  output logic [cdl_pkg::ADDR_W-1:0]        out_coef_index,
  output logic [cdl_pkg::DERIV_W-1:0]       out_deriv_coef,
  output logic                              out_line_last,
  input  logic                              cfg_we,
  input  logic [cdl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cdl_pkg::CFG_W-1:0]         cfg_data
);
  import cdl_pkg::*;

  // configuration registers
  logic [LEN_W-1:0]   line_length_r;
  logic [SCALE_W-1:0] interval_scale_r;

  // store ports
  logic               coef_we;
  logic [ADDR_W-1:0]  coef_waddr;
  logic [ADDR_W-1:0]  coef_raddr;
  logic [COEF_W-1:0]  coef_rdata;
  logic               deriv_we;
  logic [ADDR_W-1:0]  deriv_waddr;
  logic [DERIV_W-1:0] deriv_wdata;
  logic [ADDR_W-1:0]  deriv_raddr;
  logic [DERIV_W-1:0] deriv_rdata;

  recur_step_t        step;
  emit_tag_t          tag;

  // register writes take effect at once; unknown indexes cannot occur
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r    <= LINE_LENGTH_RST;
      interval_scale_r <= INTERVAL_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_LENGTH:    line_length_r    <= cfg_data[LEN_W-1:0];
        REG_INTERVAL_SCALE: interval_scale_r <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: load count, recurrence and emission addressing
  cdl_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .line_length (line_length_r),
    .coef_we     (coef_we),
    .coef_waddr  (coef_waddr),
    .coef_raddr  (coef_raddr),
    .deriv_we    (deriv_we),
    .deriv_waddr (deriv_waddr),
    .deriv_raddr (deriv_raddr),
    .step        (step),
    .tag         (tag)
  );

  // line store: written by loads, read by the recurrence
  cdl_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_LINE)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_coef_in),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // even and odd running sums
  cdl_recur u_recur (
    .clk   (clk),
    .step  (step),
    .coef  (coef_rdata),
    .wdata (deriv_wdata)
  );

  // derivative store: written by the recurrence, read out in ascending order
  cdl_ram #(
    .WIDTH (DERIV_W),
    .DEPTH (MAX_LINE)
  ) u_deriv_ram (
    .clk   (clk),
    .we    (deriv_we),
    .waddr (deriv_waddr),
    .wdata (deriv_wdata),
    .raddr (deriv_raddr),
    .rdata (deriv_rdata)
  );

  // scale, floor, saturate and drive the result strobe
  cdl_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (tag),
    .rdata     (deriv_rdata),
    .scale     (interval_scale_r),
    .out_valid (out_valid),
    .out_idx   (out_coef_index),
    .out_value (out_deriv_coef),
    .out_last  (out_line_last)
  );

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    deriv_we |-> !tag.valid)
    else $error("derivative store written while being read out");

  a_last_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_last) |=> !(out_valid && out_coef_index != '0))
    else $error("result after end of line not starting at index zero");

endmodule
